// ===== rtl/hsv_to_rgb_converter_assert.svh =====
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define H2R_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ===== rtl/h2r_pkg.sv =====
// Shared constants and types for the HSV to RGB converter.
package h2r_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CH_W          = 16;
    localparam int COLOR_W       = 8;
    localparam int LATENCY       = 5;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

endpackage

// ===== rtl/h2r_scale.sv =====
// Two-stage conversion of a 16-bit x/65535 fraction to FRAC_BITS fixed point.
module h2r_scale #(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic [h2r_pkg::CH_W-1:0]            x,
    output logic [FRAC_BITS:0]                  q
);

    localparam int NW = h2r_pkg::CH_W + FRAC_BITS;
    localparam int W  = FRAC_BITS + 1;

    logic [NW-1:0] num;
    logic [NW:0]   approx_sum;
    logic [W-1:0]  q0_next;
    logic [NW-1:0] num_reg;
    logic [W-1:0]  q0_reg;
    logic [NW:0]   q0_times;
    logic [NW:0]   rem;
    logic [W-1:0]  q_next;
    logic [W-1:0]  q_reg;

    // Estimate x * 2^F / 65535 by the series 1 + 2^-16 + 2^-32; low by at most one.
    assign num        = {x, {FRAC_BITS{1'b0}}};
    assign approx_sum = {1'b0, num} + {1'b0, (num >> 16)} + {1'b0, (num >> 32)};
    assign q0_next    = approx_sum[NW:16];

    always_ff @(posedge clk)
    begin
        num_reg <= num;
        q0_reg  <= q0_next;
    end

    // Fix the estimate up by one when the remainder reaches the divisor.
    assign q0_times = {q0_reg, 16'h0000} - {{(NW + 1 - W){1'b0}}, q0_reg};
    assign rem      = {1'b0, num_reg} - q0_times;
    assign q_next   = (rem >= (NW + 1)'(65535)) ? q0_reg + W'(1) : q0_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: five-stage pipeline, one pixel per clock.
// Takes a request whenever start is high; busy never rises, so one pixel may enter on every
// clock. Each request yields one red/green/blue triple on done exactly five cycles after it
// was taken, in order, for one cycle only: the receiver must capture it then. The five
// register stages (two for the fraction scaling, two multiply stages, one select and
// byte-scaling stage) set that latency. Zero saturation gives grey at the brightness level.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [h2r_pkg::CH_W-1:0]           hue,
    input  logic [h2r_pkg::CH_W-1:0]           saturation,
    input  logic [h2r_pkg::CH_W-1:0]           brightness,
    output logic                               done,
    output logic [h2r_pkg::COLOR_W-1:0]        red,
    output logic [h2r_pkg::COLOR_W-1:0]        green,
    output logic [h2r_pkg::COLOR_W-1:0]        blue
);

    localparam int W  = FRAC_BITS + 1;
    localparam int HW = h2r_pkg::CH_W + 3;
    localparam int BW = W + 8;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                     accept;
    logic [HW-1:0]            hue6;
    logic [h2r_pkg::CH_W+FRAC_BITS-1:0] frac_wide;
    h2r_pkg::sector_t         sec_next;
    logic [FRAC_BITS-1:0]     f_next;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    h2r_pkg::sector_t         sec1_reg, sec2_reg, sec3_reg, sec4_reg;
    logic [FRAC_BITS-1:0]     f1_reg, f2_reg;

    logic [W-1:0]             s2, v2;
    logic [W-1:0]             one_minus_f;
    logic [2*W-1:0]           sf_prod, st_prod, p_prod;
    logic [W-1:0]             sf3_reg, st3_reg, p3_reg, v3_val_reg;
    logic [2*W-1:0]           q_prod, t_prod;
    logic [W-1:0]             q4_reg, t4_reg, p4_reg, v4_val_reg;

    logic [W-1:0]             r_sel, g_sel, b_sel;
    logic [h2r_pkg::COLOR_W-1:0] red_next, green_next, blue_next;
    logic [h2r_pkg::COLOR_W-1:0] red_reg, green_reg, blue_reg;

    function automatic logic [h2r_pkg::COLOR_W-1:0] to_byte(input logic [W-1:0] x);
        logic [BW-1:0] scaled;
        scaled  = {x, 8'h00} - {8'h00, x};
        to_byte = scaled[FRAC_BITS +: h2r_pkg::COLOR_W];
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign hue6      = {hue, 2'b00} + {1'b0, hue, 1'b0};
    assign sec_next  = h2r_pkg::sector_t'(hue6[HW-1:h2r_pkg::CH_W]);
    assign frac_wide = {hue6[h2r_pkg::CH_W-1:0], {FRAC_BITS{1'b0}}};
    assign f_next    = frac_wide[h2r_pkg::CH_W +: FRAC_BITS];

    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_sat (
        .clk (clk),
        .x   (saturation),
        .q   (s2)
    );

    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_val (
        .clk (clk),
        .x   (brightness),
        .q   (v2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Hue sector and fraction ride alongside the scaling stages.
    always_ff @(posedge clk)
    begin
        sec1_reg <= sec_next;
        f1_reg   <= f_next;
        sec2_reg <= sec1_reg;
        f2_reg   <= f1_reg;
    end

    assign one_minus_f = ONE - {1'b0, f2_reg};
    assign sf_prod     = {{W{1'b0}}, s2} * {{W{1'b0}}, 1'b0, f2_reg};
    assign st_prod     = {{W{1'b0}}, s2} * {{W{1'b0}}, one_minus_f};
    assign p_prod      = {{W{1'b0}}, v2} * {{W{1'b0}}, (ONE - s2)};

    always_ff @(posedge clk)
    begin
        sf3_reg    <= sf_prod[FRAC_BITS +: W];
        st3_reg    <= st_prod[FRAC_BITS +: W];
        p3_reg     <= p_prod[FRAC_BITS +: W];
        v3_val_reg <= v2;
        sec3_reg   <= sec2_reg;
    end

    assign q_prod = {{W{1'b0}}, v3_val_reg} * {{W{1'b0}}, (ONE - sf3_reg)};
    assign t_prod = {{W{1'b0}}, v3_val_reg} * {{W{1'b0}}, (ONE - st3_reg)};

    always_ff @(posedge clk)
    begin
        q4_reg     <= q_prod[FRAC_BITS +: W];
        t4_reg     <= t_prod[FRAC_BITS +: W];
        p4_reg     <= p3_reg;
        v4_val_reg <= v3_val_reg;
        sec4_reg   <= sec3_reg;
    end

    always_comb
    begin
        case (sec4_reg)
            h2r_pkg::SEC_RED_YEL:
            begin
                r_sel = v4_val_reg; g_sel = t4_reg;     b_sel = p4_reg;
            end
            h2r_pkg::SEC_YEL_GRN:
            begin
                r_sel = q4_reg;     g_sel = v4_val_reg; b_sel = p4_reg;
            end
            h2r_pkg::SEC_GRN_CYN:
            begin
                r_sel = p4_reg;     g_sel = v4_val_reg; b_sel = t4_reg;
            end
            h2r_pkg::SEC_CYN_BLU:
            begin
                r_sel = p4_reg;     g_sel = q4_reg;     b_sel = v4_val_reg;
            end
            h2r_pkg::SEC_BLU_MAG:
            begin
                r_sel = t4_reg;     g_sel = p4_reg;     b_sel = v4_val_reg;
            end
            default:
            begin
                r_sel = v4_val_reg; g_sel = p4_reg;     b_sel = q4_reg;
            end
        endcase
    end

    assign red_next   = to_byte(r_sel);
    assign green_next = to_byte(g_sel);
    assign blue_next  = to_byte(b_sel);

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    `H2R_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised on a fully pipelined block")
    `H2R_ASSERT_NOW(a_latency, accept, ##5 done, "request did not complete after five cycles")
    `H2R_ASSERT_NOW(a_grey, done && $past(accept, 5) && $past(saturation == 0, 5), red == green && green == blue, "zero saturation did not give grey")

endmodule

// ===== tb/hsv_to_rgb_converter_test.sv =====
// Testbench for the HSV to RGB converter: directed and random pixels checked against a predictor.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_test;
    import h2r_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam logic [63:0] ONE = 64'd1 << FB;
    localparam int RANDOM_PIXELS = 1130;
    localparam int PHASE_LEN = 400;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] brightness;
    } pixel_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [CH_W-1:0] hue = '0;
    logic [CH_W-1:0] saturation = '0;
    logic [CH_W-1:0] brightness = '0;
    logic busy;
    logic done;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    pixel_req_t pixel_requests[$];
    rgb_t rgb_expected[$];
    pixel_req_t next_pixel;
    rgb_t want_rgb;
    logic req_taken = 1'b0;
    int sent_count = 0;
    int directed_count = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    hsv_to_rgb_converter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    function automatic logic [COLOR_W-1:0] scale_to_byte(input logic [63:0] x);
        logic [63:0] scaled;
        scaled = (x * 64'd255) >> FB;
        return scaled[COLOR_W-1:0];
    endfunction

    function automatic rgb_t compute_rgb(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s_in,
                                         input logic [CH_W-1:0] b_in);
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] h6;
        logic [63:0] f;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] rr;
        logic [63:0] gg;
        logic [63:0] bb;
        sector_t sec;
        rgb_t res;
        s = ({48'd0, s_in} << FB) / 64'd65535;
        v = ({48'd0, b_in} << FB) / 64'd65535;
        h6 = {48'd0, h} * 64'd6;
        sec = sector_t'(h6[18:16]);
        f = ((h6 & 64'hFFFF) << FB) >> 16;
        p = (v * (ONE - s)) >> FB;
        q = (v * (ONE - ((s * f) >> FB))) >> FB;
        t = (v * (ONE - ((s * (ONE - f)) >> FB))) >> FB;
        if (s_in == '0) begin
            rr = v;
            gg = v;
            bb = v;
        end
        else begin
            case (sec)
                SEC_RED_YEL: begin rr = v; gg = t; bb = p; end
                SEC_YEL_GRN: begin rr = q; gg = v; bb = p; end
                SEC_GRN_CYN: begin rr = p; gg = v; bb = t; end
                SEC_CYN_BLU: begin rr = p; gg = q; bb = v; end
                SEC_BLU_MAG: begin rr = t; gg = p; bb = v; end
                default:     begin rr = v; gg = p; bb = q; end
            endcase
        end
        res.red = scale_to_byte(rr);
        res.green = scale_to_byte(gg);
        res.blue = scale_to_byte(bb);
        return res;
    endfunction

    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return CH_W'($urandom_range(1, 3));
            3: return CH_W'(16'hFFFF - $urandom_range(1, 3));
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic int idle_pct();
        if (sent_count < PHASE_LEN) return 31;
        if (sent_count < 2 * PHASE_LEN) return 53;
        return 0;
    endfunction

    task automatic add_pixel(input int h, input int s, input int b);
        pixel_req_t item;
        item.hue = CH_W'(h);
        item.saturation = CH_W'(s);
        item.brightness = CH_W'(b);
        pixel_requests.push_back(item);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        int k;
        int sat;
        for (k = 0; k < 6; k++) begin
            add_pixel((k * 65536 + 5) / 6, 65535, 65535);
            add_pixel((k * 65536 + 5) / 6 + 5461, 65535, 16'hC000);
        end
        add_pixel(0, 0, 0);
        add_pixel(0, 0, 65535);
        add_pixel(16'h1234, 0, 16'h8000);
        add_pixel(65535, 65535, 65535);
        add_pixel(65535, 1, 65535);
        add_pixel(10922, 65535, 65535);
        add_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        add_pixel(16'h5555, 16'hAAAA, 16'h5555);
        add_pixel(30000, 65535, 0);
        directed_count = pixel_requests.size();
        for (k = 0; k < RANDOM_PIXELS; k++) begin
            sat = ($urandom_range(9) == 0) ? 0 : int'(pick_level());
            add_pixel(int'(pick_level()), sat, int'(pick_level()));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pixel_requests.size() != 0 || start) @(posedge clk);
        while (rgb_expected.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || req_taken) begin
            if (pixel_requests.size() == 0
                || ((sent_count == directed_count || sent_count == PHASE_LEN
                     || sent_count == 2 * PHASE_LEN) && rgb_expected.size() != 0)
                || $urandom_range(99) < idle_pct()) begin
                start <= 1'b0;
            end
            else begin
                next_pixel = pixel_requests.pop_front();
                hue <= next_pixel.hue;
                saturation <= next_pixel.saturation;
                brightness <= next_pixel.brightness;
                start <= 1'b1;
                sent_count++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (done) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no request pending",
                                              red, green, blue));
                end
                else begin
                    want_rgb = rgb_expected.pop_front();
                    if (red !== want_rgb.red)
                        report_mismatch($sformatf("red got %0d want %0d", red, want_rgb.red));
                    if (green !== want_rgb.green)
                        report_mismatch($sformatf("green got %0d want %0d",
                                                  green, want_rgb.green));
                    if (blue !== want_rgb.blue)
                        report_mismatch($sformatf("blue got %0d want %0d", blue, want_rgb.blue));
                end
            end
            if (start && !busy)
                rgb_expected.push_back(compute_rgb(hue, saturation, brightness));
            quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
            req_taken <= start && !busy;
        end
    end

    always @(posedge clk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/h2r_pkg.sv
rtl/h2r_scale.sv
rtl/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_test.sv
